FILE: hw/rtl/nrmc_pkg.sv
// Shared constants, tables and the job type for the RMC position parser.
package nrmc_pkg;

    localparam int FRACTION_DIGITS = 5;

    function automatic longint unsigned pow10_f(input int n);
        longint unsigned r;
        r = 1;
        for (int i = 0; i < n; i++) begin
            r = r * 10;
        end
        return r;
    endfunction

    localparam longint unsigned SCALE = pow10_f(FRACTION_DIGITS);

    localparam int DEG_W  = 10;
    localparam int MIN_W  = 7;
    localparam int CNT_W  = 3;
    localparam int FRAC_W = $clog2(SCALE);
    // minutes in units of 10^-F minute stay below 128 * 10^F
    localparam int M_W    = $clog2(128 * SCALE);
    localparam int X_W    = 31;
    localparam int Y_W    = X_W - 2;
    localparam int Q_W    = 25;

    localparam logic [M_W-1:0]   SCALE_C       = M_W'(SCALE);
    localparam logic [31:0]      KSCALE        = 32'(pow10_f(7 - FRACTION_DIGITS));
    localparam logic [CNT_W-1:0] F_CODE        = CNT_W'(FRACTION_DIGITS);
    localparam logic [23:0]      UNITS_PER_DEG = 24'd10000000;
    localparam logic [31:0]      MAG_LIMIT     = 32'd1800000000;
    localparam logic [DEG_W-1:0] DEG_LIMIT     = 10'd180;
    localparam logic [31:0]      RECIP15       = 32'h11111111;

    localparam logic [23:0] POW10_TBL [8] = '{
        24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000,
        24'd100000, 24'd1000000, 24'd10000000
    };

    localparam logic KIND_LAT = 1'b0;
    localparam logic KIND_LON = 1'b1;

    typedef struct packed {
        logic              kind;
        logic              neg;
        logic [DEG_W-1:0]  degree;
        logic [MIN_W-1:0]  minute;
        logic [FRAC_W-1:0] frac;
        logic [CNT_W-1:0]  count;
    } t_job;

endpackage

FILE: hw/rtl/nrmc_front.sv
// Character parser: header match, field split and coordinate digit capture.
module nrmc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_char_valid,
    output logic          o_char_ready,
    input  logic [7:0]    i_char_in,
    output logic          o_job_valid,
    output nrmc_pkg::t_job o_job,
    input  logic          i_job_ready
);
    import nrmc_pkg::*;

    typedef enum logic [2:0] {
        PEND_NONE = 3'b001,
        PEND_LAT  = 3'b010,
        PEND_LON  = 3'b100
    } t_pend;

    localparam logic [7:0] CHR_DOLLAR = 8'h24;
    localparam logic [7:0] CHR_COMMA  = 8'h2C;
    localparam logic [7:0] CHR_DOT    = 8'h2E;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_NINE   = 8'h39;
    localparam logic [7:0] CHR_O      = 8'h4F;
    localparam logic [7:0] HDR_TEXT [5] = '{8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43};
    localparam logic [2:0] HDR_LEN    = 3'd5;
    localparam logic [3:0] FIELD_LAT  = 4'd3;
    localparam logic [3:0] FIELD_LON  = 4'd5;
    localparam logic [3:0] FIELD_MAX  = 4'd15;
    localparam logic [4:0] CHARS_MAX  = 5'd31;
    localparam logic [MIN_W-1:0] MIN_MAX = 7'd127;

    logic [2:0]        r_header_pos, n_header_pos;
    logic              r_header_match, n_header_match;
    logic [3:0]        r_field_index, n_field_index;
    logic [4:0]        r_chars, n_chars;
    logic [DEG_W-1:0]  r_degree, n_degree;
    logic [MIN_W-1:0]  r_minute, n_minute;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic [CNT_W-1:0]  r_frac_cnt, n_frac_cnt;
    logic              r_dot, n_dot;
    t_pend             r_pending, n_pending;

    logic accept;

    assign o_char_ready = (r_pending == PEND_NONE) | i_job_ready;
    assign accept       = i_char_valid & o_char_ready;
    assign o_job_valid  = i_char_valid & (r_pending != PEND_NONE);

    always_comb begin
        o_job.kind   = (r_pending == PEND_LON) ? KIND_LON : KIND_LAT;
        o_job.neg    = (i_char_in > CHR_O);
        o_job.degree = r_degree;
        o_job.minute = r_minute;
        o_job.frac   = r_frac;
        o_job.count  = r_frac_cnt;
    end

    always_comb begin
        logic [3:0]        d;
        logic [4:0]        deg_digits;
        logic [DEG_W+3:0]  deg_w;
        logic [MIN_W+3:0]  min_w;
        logic [FRAC_W+3:0] frac_w;
        n_header_pos   = r_header_pos;
        n_header_match = r_header_match;
        n_field_index  = r_field_index;
        n_chars        = r_chars;
        n_degree       = r_degree;
        n_minute       = r_minute;
        n_frac         = r_frac;
        n_frac_cnt     = r_frac_cnt;
        n_dot          = r_dot;
        n_pending      = r_pending;
        d              = 4'(i_char_in - CHR_ZERO);
        deg_digits     = (r_field_index == FIELD_LAT) ? 5'd2 : 5'd3;
        deg_w          = {4'b0, r_degree} * (DEG_W+4)'(10) + (DEG_W+4)'(d);
        min_w          = {4'b0, r_minute} * (MIN_W+4)'(10) + (MIN_W+4)'(d);
        frac_w         = {4'b0, r_frac} * (FRAC_W+4)'(10) + (FRAC_W+4)'(d);
        if (accept) begin
            // the direction character closes out the pending coordinate
            if (r_pending != PEND_NONE) begin
                n_pending  = PEND_NONE;
                n_chars    = '0;
                n_degree   = '0;
                n_minute   = '0;
                n_frac     = '0;
                n_frac_cnt = '0;
                n_dot      = 1'b0;
            end
            priority if (i_char_in == CHR_DOLLAR) begin
                n_header_pos   = '0;
                n_header_match = 1'b1;
                n_field_index  = '0;
                n_chars        = '0;
                n_degree       = '0;
                n_minute       = '0;
                n_frac         = '0;
                n_frac_cnt     = '0;
                n_dot          = 1'b0;
            end else if (!r_header_match) begin
                n_header_match = 1'b0;
            end else if (r_header_pos < HDR_LEN) begin
                if (i_char_in != HDR_TEXT[r_header_pos]) begin
                    n_header_match = 1'b0;
                end
                n_header_pos = r_header_pos + 3'd1;
            end else if (i_char_in == CHR_COMMA) begin
                if (r_field_index == FIELD_LAT) begin
                    n_pending = PEND_LAT;
                end else if (r_field_index == FIELD_LON) begin
                    n_pending = PEND_LON;
                end
                if (r_field_index < FIELD_MAX) begin
                    n_field_index = r_field_index + 4'd1;
                end
            end else if (r_field_index == FIELD_LAT || r_field_index == FIELD_LON) begin
                // no coordinate can be pending here, so r_ and n_ agree
                if (i_char_in >= CHR_ZERO && i_char_in <= CHR_NINE) begin
                    if (!r_dot) begin
                        if (r_chars < deg_digits) begin
                            n_degree = deg_w[DEG_W-1:0];
                        end else begin
                            n_minute = (min_w > (MIN_W+4)'(MIN_MAX)) ? MIN_MAX
                                                                      : min_w[MIN_W-1:0];
                        end
                        if (r_chars < CHARS_MAX) begin
                            n_chars = r_chars + 5'd1;
                        end
                    end else if (r_frac_cnt < F_CODE) begin
                        n_frac     = frac_w[FRAC_W-1:0];
                        n_frac_cnt = r_frac_cnt + CNT_W'(1);
                    end
                end else if (i_char_in == CHR_DOT) begin
                    n_dot = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_pos   <= '0;
            r_header_match <= 1'b0;
            r_field_index  <= '0;
            r_chars        <= '0;
            r_degree       <= '0;
            r_minute       <= '0;
            r_frac         <= '0;
            r_frac_cnt     <= '0;
            r_dot          <= 1'b0;
            r_pending      <= PEND_NONE;
        end else begin
            r_header_pos   <= n_header_pos;
            r_header_match <= n_header_match;
            r_field_index  <= n_field_index;
            r_chars        <= n_chars;
            r_degree       <= n_degree;
            r_minute       <= n_minute;
            r_frac         <= n_frac;
            r_frac_cnt     <= n_frac_cnt;
            r_dot          <= n_dot;
            r_pending      <= n_pending;
        end
    end

endmodule

FILE: hw/rtl/nrmc_queue.sv
// Two-entry job queue between the parser and the arithmetic pipeline.
module nrmc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  nrmc_pkg::t_job i_push_job,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output nrmc_pkg::t_job o_pop_job
);
    import nrmc_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       push, pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign push         = i_push_valid & o_push_ready;
    assign pop          = o_pop_valid & i_pop_ready;
    assign o_pop_job    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr == r_rd_ptr) == (r_count != 2'd1))
        else $error("queue pointers disagree with count");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2 && !i_pop_ready) |=> (r_count == 2'd2))
        else $error("queue lost an entry while stalled");

endmodule

FILE: hw/rtl/nrmc_back.sv
// Arithmetic pipeline: degrees plus rounded minutes/60, saturate and sign.
module nrmc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    output logic                 o_job_ready,
    input  nrmc_pkg::t_job       i_job,
    output logic                 o_coord_valid,
    input  logic                 i_coord_ready,
    output logic                 o_coord_kind,
    output logic signed [31:0]   o_coord_value
);
    import nrmc_pkg::*;

    typedef struct packed {
        logic        kind;
        logic        neg;
        logic        sat;
        logic [30:0] degmul;
    } t_side;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic en1, en2, en3, en4, en5, en6;

    t_side          r1_side, r2_side, r3_side, r4_side, r5_side;
    logic [M_W-1:0] r1_pmin, r1_pfrac, r2_m;
    logic [Y_W-1:0] r3_y, r4_y;
    logic [Y_W+31:0] r4_prod;
    logic [Q_W-1:0] r5_qest;
    logic [4:0]     r5_rem;
    logic           r6_kind;
    logic [31:0]    r6_value;

    logic [FRAC_W+23:0] pfrac_w;
    logic [DEG_W+23:0]  degmul_w;
    logic [M_W+31:0]    mk_w;
    logic [X_W-1:0]     x_w;
    logic [Y_W-1:0]     rem_w;
    logic [Q_W-1:0]     q_w;
    logic [31:0]        mag_w, mag_sat;

    assign en6 = !r_v6 | i_coord_ready;
    assign en5 = !r_v5 | en6;
    assign en4 = !r_v4 | en5;
    assign en3 = !r_v3 | en4;
    assign en2 = !r_v2 | en3;
    assign en1 = !r_v1 | en2;
    assign o_job_ready = en1;

    assign o_coord_valid = r_v6;
    assign o_coord_kind  = r6_kind;
    assign o_coord_value = $signed(r6_value);

    // stage 1 products, stage 3 scale to 1e-7 minute plus half of 60
    assign pfrac_w  = i_job.frac * POW10_TBL[F_CODE - i_job.count];
    assign degmul_w = i_job.degree * UNITS_PER_DEG;
    assign mk_w     = r2_m * KSCALE;
    assign x_w      = mk_w[X_W-1:0] + X_W'(30);
    // y / 15 by reciprocal: estimate is exact or one low, remainder below 30
    assign rem_w    = r4_y - {r4_prod[Y_W+27:32], 4'b0} + Y_W'(r4_prod[Q_W+31:32]);
    assign q_w      = r5_qest + Q_W'(r5_rem >= 5'd15);
    assign mag_w    = {1'b0, r5_side.degmul} + 32'(q_w);
    assign mag_sat  = (r5_side.sat || mag_w > MAG_LIMIT) ? MAG_LIMIT : mag_w;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_pmin        <= M_W'(i_job.minute * SCALE_C);
            r1_pfrac       <= pfrac_w[M_W-1:0];
            r1_side.kind   <= i_job.kind;
            r1_side.neg    <= i_job.neg;
            r1_side.sat    <= (i_job.degree > DEG_LIMIT);
            r1_side.degmul <= degmul_w[30:0];
        end
        if (en2) begin
            r2_m    <= r1_pmin + r1_pfrac;
            r2_side <= r1_side;
        end
        if (en3) begin
            r3_y    <= x_w[X_W-1:2];
            r3_side <= r2_side;
        end
        if (en4) begin
            r4_prod <= r3_y * RECIP15;
            r4_y    <= r3_y;
            r4_side <= r3_side;
        end
        if (en5) begin
            r5_qest <= r4_prod[Q_W+31:32];
            r5_rem  <= rem_w[4:0];
            r5_side <= r4_side;
        end
        if (en6) begin
            r6_kind  <= r5_side.kind;
            r6_value <= r5_side.neg ? (32'd0 - mag_sat) : mag_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_job_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    a_minutes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r2_m < M_W'(128 * SCALE)))
        else $error("minute value out of range");

    a_recip_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (r5_rem < 5'd30))
        else $error("reciprocal estimate off by more than one");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_coord_valid |-> (o_coord_value <= 32'sd1800000000 &&
                           o_coord_value >= -32'sd1800000000))
        else $error("coordinate beyond limit");

endmodule

FILE: hw/rtl/nmea_rmc_position_parser_core.sv
// Top level of the RMC position parser: parser, job queue, arithmetic pipeline.
//
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+------------------------------
//  char     | in        | i_char_valid / o_char_ready    | i_char_in[7:0]
//  coord    | out       | o_coord_valid / i_coord_ready  | o_coord_kind, o_coord_value
//
// One character per cycle is taken unless the parser stalls; its state is registered.
// A coordinate follows its direction character through the queue and the arithmetic
// pipeline (divide by 60: shift by two, then reciprocal divide by 15 over three stages).
// The parser stalls only when a coordinate is due and the 2-entry queue is full.
// Synchronous active-low reset clears control state; nothing to sweep afterwards.
module nmea_rmc_position_parser_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_char_valid,
    output logic               o_char_ready,
    input  logic [7:0]         i_char_in,
    output logic               o_coord_valid,
    input  logic               i_coord_ready,
    output logic               o_coord_kind,
    output logic signed [31:0] o_coord_value
);
    import nrmc_pkg::*;

    logic fe_valid, fe_ready;
    logic q_valid, q_ready;
    t_job fe_job, q_job;

    nrmc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_valid (i_char_valid),
        .o_char_ready (o_char_ready),
        .i_char_in    (i_char_in),
        .o_job_valid  (fe_valid),
        .o_job        (fe_job),
        .i_job_ready  (fe_ready)
    );

    nrmc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fe_valid),
        .o_push_ready (fe_ready),
        .i_push_job   (fe_job),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_job    (q_job)
    );

    nrmc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_valid),
        .o_job_ready   (q_ready),
        .i_job         (q_job),
        .o_coord_valid (o_coord_valid),
        .i_coord_ready (i_coord_ready),
        .o_coord_kind  (o_coord_kind),
        .o_coord_value (o_coord_value)
    );

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the RMC position parser core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nrmc_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int MAX_WAIT    = 16;
    localparam int RAND_CHARS  = 1750;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 30;
    localparam int MAX_REPORTS = 10;
    localparam int MIN_CAP     = 127;
    localparam int INT_CAP     = 31;
    localparam int FIELD_CAP   = 15;
    localparam int LAT_FIELD   = 3;
    localparam int LON_FIELD   = 5;

    localparam longint unsigned DEG_UNITS = 64'd10000000;
    localparam longint unsigned MAG_CAP   = 64'd1800000000;

    localparam logic [7:0] CH_DOLLAR  = "$";
    localparam logic [7:0] CH_COMMA   = ",";
    localparam logic [7:0] CH_DOT     = ".";
    localparam logic [7:0] CH_ZERO    = "0";
    localparam logic [7:0] CH_NINE    = "9";
    localparam logic [7:0] CH_FILL    = "A";
    localparam logic [7:0] CH_DIR_MID = "O"; // direction codes above this negate
    localparam logic [7:0] RMC_TAG [5]   = '{"G", "N", "R", "M", "C"};
    localparam logic [7:0] DIR_CHARS [4] = '{"N", "S", "E", "W"};

    typedef enum logic [1:0] {PEND_NONE, PEND_LAT, PEND_LON} t_pend;

    typedef struct {
        logic               kind;
        logic signed [31:0] value;
    } t_coord;

    typedef struct {
        logic [7:0] ch;
        bit         fixed;
        bit         drain;
        t_coord     want;
    } t_char_item;

    typedef struct {
        string text;
        bit    fixed;
        logic  kind;
        int    value;
    } t_dir_row;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_char_valid  = 1'b0;
    logic               o_char_ready;
    logic [7:0]         i_char_in     = 8'h00;
    logic               o_coord_valid;
    logic               i_coord_ready = 1'b0;
    logic               o_coord_kind;
    logic signed [31:0] o_coord_value;

    // parser state mirror
    logic [2:0]        tag_pos;
    logic              tag_ok;
    logic [3:0]        field_no;
    logic [4:0]        int_digits;
    logic [DEG_W-1:0]  deg_acc;
    logic [MIN_W-1:0]  min_acc;
    logic [FRAC_W-1:0] frac_acc;
    logic [CNT_W-1:0]  frac_cnt;
    logic              dot_flag;
    t_pend             pend;

    t_char_item stim_q[$];
    t_coord     exp_coords[$];
    int         mismatches   = 0;
    int         useful_chars = 0;
    int         idle_cycles  = 0;
    bit         live         = 1'b1;
    bit         drain_next   = 1'b0;

    // last character of a row carries the typed expectation, if any
    t_dir_row dir_rows [6] = '{
        '{"#\377$GNRMX,,,12,N,", 1'b0, KIND_LAT, 0},
        '{"$GNRMC,,,,N", 1'b1, KIND_LAT, 0},
        '{",99999.9999999,W", 1'b1, KIND_LON, -1800000000},
        '{"$GNRMC,,,4916.45,S,12311.12,E", 1'b0, KIND_LAT, 0},
        '{"$GNRMC,,,0130.5.6789012,$", 1'b0, KIND_LAT, 0},
        '{"GNRMC,,,,,18000,\200", 1'b0, KIND_LAT, 0}
    };

    nmea_rmc_position_parser_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_char_valid  (i_char_valid),
        .o_char_ready  (o_char_ready),
        .i_char_in     (i_char_in),
        .o_coord_valid (o_coord_valid),
        .i_coord_ready (i_coord_ready),
        .o_coord_kind  (o_coord_kind),
        .o_coord_value (o_coord_value)
    );

    initial begin : clk_gen
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void clear_field();
        int_digits = '0;
        deg_acc    = '0;
        min_acc    = '0;
        frac_acc   = '0;
        frac_cnt   = '0;
        dot_flag   = 1'b0;
    endfunction

    // degrees + minutes/60 in 1e-7 degree, rounded half up, saturated
    function automatic logic signed [31:0] coord_fixed(input logic [7:0] dir);
        longint unsigned scale;
        longint unsigned pad;
        longint unsigned minutes;
        longint unsigned den;
        longint unsigned mag;
        scale = 1;
        for (int i = 0; i < FRACTION_DIGITS; i++) scale = scale * 10;
        pad = 1;
        for (int i = int'(frac_cnt); i < FRACTION_DIGITS; i++) pad = pad * 10;
        minutes = min_acc * scale + frac_acc * pad;
        den     = 60 * scale;
        mag     = deg_acc * DEG_UNITS + (minutes * DEG_UNITS + den / 2) / den;
        if (mag > MAG_CAP) mag = MAG_CAP;
        return (dir > CH_DIR_MID) ? -$signed(mag[31:0]) : $signed(mag[31:0]);
    endfunction

    function automatic bit parse_char(input logic [7:0] c, output t_coord res);
        bit got;
        int deg_digits;
        int v;
        got       = 1'b0;
        res.kind  = KIND_LAT;
        res.value = '0;
        if (pend != PEND_NONE) begin
            got       = 1'b1;
            res.kind  = (pend == PEND_LON) ? KIND_LON : KIND_LAT;
            res.value = coord_fixed(c);
            pend      = PEND_NONE;
            clear_field();
        end
        if (c == CH_DOLLAR) begin
            tag_pos  = '0;
            tag_ok   = 1'b1;
            field_no = '0;
            clear_field();
        end else if (tag_ok) begin
            if (tag_pos < 5) begin
                // header bytes are only compared, never parsed
                if (c != RMC_TAG[tag_pos]) tag_ok = 1'b0;
                tag_pos++;
            end else if (c == CH_COMMA) begin
                if (field_no == LAT_FIELD) pend = PEND_LAT;
                else if (field_no == LON_FIELD) pend = PEND_LON;
                if (field_no < FIELD_CAP) field_no++;
            end else if (field_no == LAT_FIELD || field_no == LON_FIELD) begin
                deg_digits = (field_no == LAT_FIELD) ? 2 : 3;
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    if (!dot_flag) begin
                        if (int_digits < deg_digits) begin
                            deg_acc = deg_acc * 10 + (c - CH_ZERO);
                        end else begin
                            v       = min_acc * 10 + (c - CH_ZERO);
                            min_acc = (v > MIN_CAP) ? MIN_W'(MIN_CAP) : MIN_W'(v);
                        end
                        if (int_digits < INT_CAP) int_digits++;
                    end else if (frac_cnt < FRACTION_DIGITS) begin
                        frac_acc = frac_acc * 10 + (c - CH_ZERO);
                        frac_cnt++;
                    end
                end else if (c == CH_DOT) begin
                    dot_flag = 1'b1;
                end
            end
        end
        return got;
    endfunction

    function automatic void push_ch(input logic [7:0] c);
        t_char_item it;
        it.ch         = c;
        it.fixed      = 1'b0;
        it.drain      = drain_next;
        it.want.kind  = KIND_LAT;
        it.want.value = '0;
        drain_next    = 1'b0;
        stim_q.push_back(it);
        useful_chars++;
    endfunction

    function automatic logic [7:0] filler_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CH_COMMA || c == CH_DOLLAR) c = CH_FILL;
        return c;
    endfunction

    function automatic void push_digit();
        push_ch(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void push_filler(input int max_len);
        int n;
        n = $urandom_range(0, max_len);
        for (int k = 0; k < n; k++) push_ch(filler_byte());
    endfunction

    function automatic void push_num(input int value, input int digits);
        int div;
        div = 1;
        for (int k = 1; k < digits; k++) div = div * 10;
        for (int k = 0; k < digits; k++) begin
            push_ch(CH_ZERO + 8'((value / div) % 10));
            div = div / 10;
        end
    endfunction

    function automatic void push_dir();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) push_ch(DIR_CHARS[$urandom_range(0, 3)]);
        else if (pick == 7) push_ch(CH_COMMA);
        else push_ch(8'($urandom_range(0, 255)));
    endfunction

    function automatic void push_coord(input int deg_digits);
        int pick;
        int n;
        pick = $urandom_range(0, 9);
        if (pick == 1) begin
            // digits, stray dots and junk mixed
            n = $urandom_range(1, 14);
            for (int k = 0; k < n; k++) begin
                pick = $urandom_range(0, 9);
                if (pick < 5) push_digit();
                else if (pick < 7) push_ch(CH_DOT);
                else push_ch(filler_byte());
            end
        end else if (pick == 2) begin
            // long integer part: minutes and digit count saturate
            n = $urandom_range(0, 35);
            for (int k = 0; k < n; k++) push_digit();
            push_ch(CH_DOT);
            n = $urandom_range(0, 9);
            for (int k = 0; k < n; k++) push_digit();
        end else if (pick > 2) begin
            push_num($urandom_range(0, (deg_digits == 2) ? 90 : 180), deg_digits);
            push_num($urandom_range(0, (pick == 3) ? 99 : 59), 2);
            if (pick != 4) push_ch(CH_DOT);
            n = $urandom_range(0, 8);
            for (int k = 0; k < n; k++) push_digit();
        end
    endfunction

    function automatic void add_sentence();
        int roll;
        int bad_pos;
        int n;
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            live = 1'b0;
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) push_ch(8'($urandom_range(0, 255)));
            return;
        end
        live    = (roll >= 14);
        bad_pos = $urandom_range(0, 4);
        if ($urandom_range(0, 24) == 0) drain_next = 1'b1;
        push_ch(CH_DOLLAR);
        for (int k = 0; k < 5; k++) begin
            if (!live && k == bad_pos)
                push_ch($urandom_range(0, 1) ? CH_COMMA : 8'($urandom_range(0, 255)));
            else
                push_ch(RMC_TAG[k]);
        end
        push_ch(CH_COMMA);
        push_filler(10);
        push_ch(CH_COMMA);
        push_filler(2);
        push_ch(CH_COMMA);
        push_coord(2);
        push_ch(CH_COMMA);
        push_dir();
        push_ch(CH_COMMA);
        push_coord(3);
        push_ch(CH_COMMA);
        push_dir();
        n = $urandom_range(0, 4);
        for (int k = 0; k < n; k++) begin
            push_ch(CH_COMMA);
            push_filler(6);
        end
    endfunction

    initial begin : main_seq
        t_char_item it;
        t_coord     res;
        bit         got;
        bit         calm;
        int         gap;
        int         len;

        tag_pos  = '0;
        tag_ok   = 1'b0;
        field_no = '0;
        pend     = PEND_NONE;
        clear_field();
        calm     = 1'b0;

        foreach (dir_rows[r]) begin
            len = dir_rows[r].text.len();
            for (int k = 0; k < len; k++) push_ch(dir_rows[r].text[k]);
            if (dir_rows[r].fixed) begin
                it            = stim_q.pop_back();
                it.fixed      = 1'b1;
                it.want.kind  = dir_rows[r].kind;
                it.want.value = dir_rows[r].value;
                stim_q.push_back(it);
            end
        end
        useful_chars = 0;
        drain_next   = 1'b1;
        while (useful_chars < RAND_CHARS) add_sentence();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < stim_q.size(); n++) begin
            it = stim_q[n];
            if (n % 48 == 0) calm = ($urandom_range(0, 3) == 0);
            gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (gap > 0 || (it.drain && exp_coords.size() != 0)) begin
                i_char_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                // hold off until every coordinate in flight has come out
                if (it.drain) while (exp_coords.size() != 0) @(posedge i_clk);
            end
            i_char_valid <= 1'b1;
            i_char_in    <= it.ch;
            // ready is registered state, so mid-cycle it shows the coming edge
            @(negedge i_clk);
            while (!o_char_ready) @(negedge i_clk);
            @(posedge i_clk);
            got = parse_char(it.ch, res);
            if (it.fixed) exp_coords.push_back(it.want);
            else if (got) exp_coords.push_back(res);
        end
        i_char_valid <= 1'b0;

        while (exp_coords.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial begin : coord_sink
        t_coord want;
        int     stall;
        int     taken;
        bit     calm;
        taken = 0;
        calm  = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken % 20 == 0) calm = ($urandom_range(0, 3) == 0);
            stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                i_coord_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_coord_ready <= 1'b1;
            @(negedge i_clk);
            while (!o_coord_valid) @(negedge i_clk);
            // one coord transaction is taken at the coming edge
            taken++;
            if (exp_coords.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected coord: kind %0d value %0d",
                             o_coord_kind, o_coord_value);
            end else begin
                want = exp_coords.pop_front();
                if (o_coord_kind !== want.kind || o_coord_value !== want.value) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"coord mismatch: exp kind %0d value %0d,",
                                  " got kind %0d value %0d"},
                                 want.kind, want.value, o_coord_kind, o_coord_value);
                end
            end
            @(posedge i_clk);
        end
    end

    // stall watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_char_valid && o_char_ready) || (o_coord_valid && i_coord_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
